// ===== rtl/tpsg_pkg.sv =====
// Shared types, constants and the length table of the pulse sound generator.
package tpsg_pkg;

	localparam int SCALE_W      = 40;
	localparam int PHASE_W      = 32;
	localparam int PERIOD_W     = 11;
	localparam int DIVISOR_W    = PERIOD_W + 1;
	localparam int STEP_CNT_W   = $clog2(SCALE_W);
	localparam int LEN_W        = 8;
	localparam int CTRL_W       = 8;
	localparam int ACC_W        = 13;
	localparam int TOTAL_W      = 17;
	localparam int TICK_W       = 4;
	localparam int LEVEL_W      = 6;
	localparam int NUM_CH       = 2;

	localparam logic [ACC_W-1:0]   FRAME_PERIOD = 13'd7457;
	localparam logic [SCALE_W-1:0] SCALE_RESET  = 40'd10894297763;

	// Address decode: 0x4000..0x4007 channel registers, 0x4015 enable mask.
	localparam logic [12:0] CH_ADDR_BLOCK = 13'h0800;
	localparam logic [15:0] ENABLE_ADDR   = 16'h4015;

	localparam logic [1:0] REG_CTRL      = 2'd0;
	localparam logic [1:0] REG_PERIOD_LO = 2'd2;
	localparam logic [1:0] REG_PERIOD_HI = 2'd3;

	localparam int HALT_BIT = 5;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_STATUS  = 2'd1,
		OP_ADVANCE = 2'd2,
		OP_SAMPLE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADV,
		ST_DIV,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic              done;
		logic [TICK_W-1:0] ticks;
	} frame_res_t;

	typedef struct packed {
		logic               done;
		logic [PHASE_W-1:0] quotient;
	} div_res_t;

	function automatic logic [LEN_W-1:0] len_lookup(input logic [4:0] idx);
		logic [LEN_W-1:0] v;
		case (idx)
			5'd0:  v = 8'd10;
			5'd1:  v = 8'd254;
			5'd2:  v = 8'd20;
			5'd3:  v = 8'd2;
			5'd4:  v = 8'd40;
			5'd5:  v = 8'd4;
			5'd6:  v = 8'd80;
			5'd7:  v = 8'd6;
			5'd8:  v = 8'd160;
			5'd9:  v = 8'd8;
			5'd10: v = 8'd60;
			5'd11: v = 8'd10;
			5'd12: v = 8'd14;
			5'd13: v = 8'd12;
			5'd14: v = 8'd26;
			5'd15: v = 8'd14;
			5'd16: v = 8'd12;
			5'd17: v = 8'd16;
			5'd18: v = 8'd24;
			5'd19: v = 8'd18;
			5'd20: v = 8'd48;
			5'd21: v = 8'd20;
			5'd22: v = 8'd96;
			5'd23: v = 8'd22;
			5'd24: v = 8'd192;
			5'd25: v = 8'd24;
			5'd26: v = 8'd72;
			5'd27: v = 8'd26;
			5'd28: v = 8'd16;
			5'd29: v = 8'd28;
			5'd30: v = 8'd32;
			5'd31: v = 8'd30;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/tpsg_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, low PHASE_W bits kept.
module tpsg_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [tpsg_pkg::SCALE_W-1:0]    dividend,
	input  logic [tpsg_pkg::DIVISOR_W-1:0]  divisor,
	output tpsg_pkg::div_res_t              res
);
	import tpsg_pkg::*;

	localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(SCALE_W - 1);

	logic                    busy_q;
	logic                    done_q;
	logic [STEP_CNT_W-1:0]   cnt_q;
	logic [SCALE_W-1:0]      dvd_q;
	logic [DIVISOR_W-2:0]    rem_q;
	logic [DIVISOR_W-1:0]    dsr_q;
	logic [PHASE_W-1:0]      quo_q;

	logic [DIVISOR_W-1:0]    trial;
	logic                    qbit;
	logic [DIVISOR_W-1:0]    diff;

	assign trial = {rem_q, dvd_q[SCALE_W-1]};
	assign qbit  = (trial >= dsr_q);
	assign diff  = trial - dsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift one dividend bit into the remainder per cycle; upper quotient bits fall off.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SCALE_W-2:0], 1'b0};
			rem_q <= qbit ? diff[DIVISOR_W-2:0] : trial[DIVISOR_W-2:0];
			quo_q <= {quo_q[PHASE_W-2:0], qbit};
		end
	end

	assign res.done     = done_q;
	assign res.quotient = quo_q;

endmodule

// ===== rtl/tpsg_frame.sv =====
// Frame cycle accumulator: counts length ticks by serial subtraction of the frame period.
module tpsg_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [15:0]          cycle_count,
	output tpsg_pkg::frame_res_t res
);
	import tpsg_pkg::*;

	logic                 busy_q;
	logic [ACC_W-1:0]     acc_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [TICK_W-1:0]    ticks_q;
	logic                 below;

	assign below = (total_q < TOTAL_W'(FRAME_PERIOD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			acc_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && below) begin
			busy_q <= 1'b0;
			acc_q  <= total_q[ACC_W-1:0];
		end
	end

	// Take off one frame period per cycle until the remainder fits.
	always_ff @(posedge clk) begin
		if (start) begin
			total_q <= TOTAL_W'(acc_q) + TOTAL_W'(cycle_count);
			ticks_q <= '0;
		end else if (busy_q && !below) begin
			total_q <= total_q - TOTAL_W'(FRAME_PERIOD);
			ticks_q <= ticks_q + 1'b1;
		end
	end

	assign res.done  = busy_q && below;
	assign res.ticks = ticks_q;

endmodule

// ===== rtl/two_channel_pulse_sound_generator_unit.sv =====
// Two pulse sound channels with bus registers, length counters and serial phase dividers.
//
//  port group   direction  handshake            payload
//  in           input      in_valid / in_stall   opcode, bus_address, write_data, cycle_count
//  out          output     out_valid / out_stall status_bits, sample_level
//  cfg          input      cfg_write_en          cfg_write_data (phase_step_scale)
//
// Register writes and status reads load their result into the output register at the accept edge.
// An advance runs the frame counter, which removes one period per cycle.
// A sample runs the two bit-serial dividers (one quotient bit per cycle).
// arst_n clears all channel state, the frame accumulator and the output valid flag.
// A new item is taken while the unit is idle and the output register is empty or being drained; a finished
// result waits in the output register or the hold state while out_stall is high.
module two_channel_pulse_sound_generator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic [15:0]                   bus_address,
	input  logic [7:0]                    write_data,
	input  logic [15:0]                   cycle_count,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status_bits,
	output logic signed [tpsg_pkg::LEVEL_W-1:0] sample_level,
	input  logic                          cfg_write_en,
	input  logic [tpsg_pkg::SCALE_W-1:0]  cfg_write_data
);
	import tpsg_pkg::*;

	state_t state_q, state_d;

	logic [SCALE_W-1:0]   scale_q;
	logic [CTRL_W-1:0]    ctrl_q   [NUM_CH];
	logic [PERIOD_W-1:0]  period_q [NUM_CH];
	logic [LEN_W-1:0]     len_q    [NUM_CH];
	logic [NUM_CH-1:0]    en_q;
	logic [PHASE_W-1:0]   phase_q  [NUM_CH];

	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [LEVEL_W-1:0]   level_q;
	logic [LEVEL_W-1:0]   res_level_q;

	logic                 accept;
	logic                 out_free;
	logic                 frame_start;
	logic                 div_start;
	logic                 hold_load;
	op_t                  op;

	frame_res_t           frame_res;
	div_res_t             div_res  [NUM_CH];

	logic [NUM_CH-1:0]    active;
	logic [NUM_CH-1:0]    live;
	logic [PHASE_W-1:0]   new_phase [NUM_CH];
	logic [LEVEL_W-1:0]   contrib   [NUM_CH];
	logic [LEVEL_W-1:0]   mix;
	logic [1:0]           status_now;

	assign op       = op_t'(opcode);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	tpsg_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (frame_start),
		.cycle_count(cycle_count),
		.res        (frame_res)
	);

	for (genvar c = 0; c < NUM_CH; c++) begin : g_div
		tpsg_div u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.start   (div_start),
			.dividend(scale_q),
			.divisor (DIVISOR_W'(period_q[c]) + 1'b1),
			.res     (div_res[c])
		);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_ADVANCE) state_d = ST_ADV;
				else if (accept && op == OP_SAMPLE) state_d = ST_DIV;
			end
			ST_ADV:  if (frame_res.done) state_d = ST_HOLD;
			ST_DIV:  if (div_res[0].done) state_d = ST_HOLD;
			ST_HOLD: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Controls.
	always_comb begin
		frame_start = 1'b0;
		div_start   = 1'b0;
		hold_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				frame_start = accept && op == OP_ADVANCE;
				div_start   = accept && op == OP_SAMPLE;
			end
			ST_HOLD: hold_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Channel level: live channels step their phase and give +volume below the duty threshold.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			active[c]    = en_q[c] && (len_q[c] != '0);
			live[c]      = active[c] && (period_q[c][PERIOD_W-1:3] != '0);
			new_phase[c] = phase_q[c] + div_res[c].quotient;
			contrib[c]   = '0;
			if (live[c]) begin
				logic below;
				case (ctrl_q[c][7:6])
					2'd0:    below = new_phase[c][PHASE_W-1 -: 3] < 3'd1;
					2'd1:    below = new_phase[c][PHASE_W-1 -: 3] < 3'd2;
					2'd2:    below = new_phase[c][PHASE_W-1 -: 3] < 3'd4;
					default: below = new_phase[c][PHASE_W-1 -: 3] < 3'd6;
				endcase
				contrib[c] = below ? LEVEL_W'(ctrl_q[c][3:0])
				                   : LEVEL_W'(-LEVEL_W'(ctrl_q[c][3:0]));
			end
		end
		mix        = contrib[0] + contrib[1];
		status_now = active;
	end

	// Channel registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			en_q    <= '0;
			for (int c = 0; c < NUM_CH; c++) begin
				ctrl_q[c]   <= '0;
				period_q[c] <= '0;
				len_q[c]    <= '0;
				phase_q[c]  <= '0;
			end
		end else begin
			if (cfg_write_en) scale_q <= cfg_write_data;
			if (accept && op == OP_WRITE) begin
				if (bus_address == ENABLE_ADDR) begin
					en_q <= write_data[NUM_CH-1:0];
					for (int c = 0; c < NUM_CH; c++)
						if (!write_data[c]) len_q[c] <= '0;
				end else if (bus_address[15:3] == CH_ADDR_BLOCK) begin
					case (bus_address[1:0])
						REG_CTRL:      ctrl_q[bus_address[2]] <= write_data;
						REG_PERIOD_LO: period_q[bus_address[2]][7:0] <= write_data;
						REG_PERIOD_HI: begin
							period_q[bus_address[2]][PERIOD_W-1:8] <= write_data[2:0];
							len_q[bus_address[2]] <= len_lookup(write_data[7:3]);
						end
						default: ;
					endcase
				end
			end
			if (state_q == ST_ADV && frame_res.done) begin
				for (int c = 0; c < NUM_CH; c++) begin
					if (!ctrl_q[c][HALT_BIT]) begin
						if (LEN_W'(frame_res.ticks) >= len_q[c]) len_q[c] <= '0;
						else len_q[c] <= len_q[c] - LEN_W'(frame_res.ticks);
					end
				end
			end
			if (state_q == ST_DIV && div_res[0].done) begin
				for (int c = 0; c < NUM_CH; c++)
					if (live[c]) phase_q[c] <= new_phase[c];
			end
		end
	end

	// Hold the mixed level (zero for an advance) until the output register is free.
	always_ff @(posedge clk) begin
		if (state_q == ST_ADV && frame_res.done) res_level_q <= '0;
		else if (state_q == ST_DIV && div_res[0].done) res_level_q <= mix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if ((accept && (op == OP_WRITE || op == OP_STATUS)) || hold_load) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept && (op == OP_WRITE || op == OP_STATUS)) begin
			status_q <= (op == OP_STATUS) ? status_now : 2'b00;
			level_q  <= '0;
		end else if (hold_load) begin
			status_q <= 2'b00;
			level_q  <= res_level_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status_bits  = status_q;
	assign sample_level = level_q;

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_res[0].done |-> state_q == ST_DIV)
		else $error("divider finished outside a sample");

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		div_res[0].done == div_res[1].done)
		else $error("channel dividers out of step");

	a_frame_in_adv_state: assert property (@(posedge clk) disable iff (!arst_n)
		frame_res.done |-> state_q == ST_ADV)
		else $error("frame counter finished outside an advance");

	a_level_without_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && level_q != '0) |-> status_q == 2'b00)
		else $error("item carries both level and status");

endmodule

// ===== tb/two_channel_pulse_sound_generator_unit_tb.sv =====
// Testbench for the two-channel pulse sound generator: directed and random bus traffic checked against a predictor.
`timescale 1ns / 100ps

class pulse_scoreboard;
	bit [39:0] scale;
	bit [7:0]  ctrl [2];
	bit [10:0] period [2];
	bit [7:0]  len [2];
	bit        en [2];
	bit [31:0] phase [2];
	int unsigned frame_acc;
	bit [7:0]  len_table [32];
	bit [1:0]  status_q [$];
	bit [5:0]  level_q [$];
	int        errors;

	localparam int unsigned FRAME_CYCLES = 7457;
	localparam bit [39:0]   SCALE_AT_RESET = 40'd10894297763;

	function new();
		int c;
		len_table = '{8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
			8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
			8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
			8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30};
		scale = SCALE_AT_RESET;
		for (c = 0; c < 2; c++) begin
			ctrl[c] = '0;
			period[c] = '0;
			len[c] = '0;
			en[c] = 1'b0;
			phase[c] = '0;
		end
		frame_acc = 0;
		errors = 0;
	endfunction

	function void set_scale(bit [39:0] v);
		scale = v;
	endfunction

	function int pending();
		return status_q.size();
	endfunction

	function void bus_write(bit [15:0] addr, bit [7:0] data);
		int c;
		if (addr == tpsg_pkg::ENABLE_ADDR) begin
			for (c = 0; c < 2; c++) begin
				en[c] = data[c];
				if (!data[c])
					len[c] = '0;
			end
		end else if (addr[15:3] == tpsg_pkg::CH_ADDR_BLOCK) begin
			c = addr[2];
			case (addr[1:0])
				tpsg_pkg::REG_CTRL: ctrl[c] = data;
				tpsg_pkg::REG_PERIOD_LO: period[c][7:0] = data;
				tpsg_pkg::REG_PERIOD_HI: begin
					period[c][10:8] = data[2:0];
					len[c] = len_table[data[7:3]];
				end
				default: ;
			endcase
		end
	endfunction

	function void advance_frames(bit [15:0] cyc);
		int unsigned total;
		int unsigned ticks;
		int c;
		total = frame_acc + cyc;
		ticks = total / FRAME_CYCLES;
		frame_acc = total % FRAME_CYCLES;
		for (c = 0; c < 2; c++) begin
			if (!ctrl[c][tpsg_pkg::HALT_BIT])
				len[c] = (ticks >= len[c]) ? 8'd0 : len[c] - 8'(ticks);
		end
	endfunction

	// Step the phase of a live channel and return its signed contribution.
	function int channel_level(int c);
		bit [39:0] step;
		bit [31:0] thresh;
		int vol;
		if (!en[c] || len[c] == 0 || period[c] < 11'd8)
			return 0;
		step = scale / ({29'd0, period[c]} + 40'd1);
		phase[c] = phase[c] + step[31:0];
		case (ctrl[c][7:6])
			2'd0: thresh = 32'h2000_0000;
			2'd1: thresh = 32'h4000_0000;
			2'd2: thresh = 32'h8000_0000;
			default: thresh = 32'hC000_0000;
		endcase
		vol = ctrl[c][3:0];
		return (phase[c] < thresh) ? vol : -vol;
	endfunction

	function void note_item(tpsg_pkg::op_t op, bit [15:0] addr, bit [7:0] data, bit [15:0] cyc);
		bit [1:0] st;
		int lvl;
		st = '0;
		lvl = 0;
		case (op)
			tpsg_pkg::OP_WRITE: bus_write(addr, data);
			tpsg_pkg::OP_STATUS: begin
				st[0] = en[0] && len[0] != 0;
				st[1] = en[1] && len[1] != 0;
			end
			tpsg_pkg::OP_ADVANCE: advance_frames(cyc);
			default: begin
				lvl = channel_level(0);
				lvl = lvl + channel_level(1);
			end
		endcase
		status_q.push_back(st);
		level_q.push_back(6'(lvl));
	endfunction

	task report(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task check_result(bit [1:0] st, bit [5:0] lvl);
		bit [1:0] exp_st;
		bit [5:0] exp_lvl;
		if (status_q.size() == 0) begin
			report($sformatf("result with no item pending: status %0d level %0d",
				st, $signed(lvl)));
			return;
		end
		exp_st = status_q.pop_front();
		exp_lvl = level_q.pop_front();
		if (st != exp_st)
			report($sformatf("status_bits %0d, predicted %0d", st, exp_st));
		if (lvl != exp_lvl)
			report($sformatf("sample_level %0d, predicted %0d", $signed(lvl), $signed(exp_lvl)));
	endtask
endclass

module two_channel_pulse_sound_generator_unit_tb;
	import tpsg_pkg::*;

	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int ITEMS_PER_PHASE = 330;
	localparam int NUM_PHASES      = 5;
	localparam int DRAIN_CYCLES    = 60;

	localparam logic [15:0] ADDR_CTRL1   = 16'h4000;
	localparam logic [15:0] ADDR_SWEEP1  = 16'h4001;
	localparam logic [15:0] ADDR_PLO1    = 16'h4002;
	localparam logic [15:0] ADDR_PHI1    = 16'h4003;
	localparam logic [15:0] ADDR_CTRL2   = 16'h4004;
	localparam logic [15:0] ADDR_SWEEP2  = 16'h4005;
	localparam logic [15:0] ADDR_PLO2    = 16'h4006;
	localparam logic [15:0] ADDR_PHI2    = 16'h4007;
	localparam logic [15:0] ADDR_FRAME   = 16'h4017;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         opcode;
	logic [15:0]        bus_address;
	logic [7:0]         write_data;
	logic [15:0]        cycle_count;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status_bits;
	logic signed [LEVEL_W-1:0] sample_level;
	logic               cfg_write_en;
	logic [SCALE_W-1:0] cfg_write_data;

	pulse_scoreboard sb;
	bit idle_on;
	int cycle_cnt;
	int useful_items;

	two_channel_pulse_sound_generator_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.bus_address    (bus_address),
		.write_data     (write_data),
		.cycle_count    (cycle_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status_bits    (status_bits),
		.sample_level   (sample_level),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_write_en)
				sb.set_scale(cfg_write_data);
			if (in_valid && !in_stall)
				sb.note_item(op_t'(opcode), bus_address, write_data, cycle_count);
			if (out_valid && !out_stall)
				sb.check_result(status_bits, sample_level);
		end
	end

	// Receiver: stall in random bursts while idling is on.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(op_t op, logic [15:0] addr, logic [7:0] data, logic [15:0] cyc);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		bus_address <= addr;
		write_data <= data;
		cycle_count <= cyc;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic bus_wr(logic [15:0] addr, logic [7:0] data);
		send_item(OP_WRITE, addr, data, 16'($urandom));
	endtask

	task automatic sample_item();
		send_item(OP_SAMPLE, 16'($urandom), 8'($urandom), 16'($urandom));
	endtask

	task automatic status_item();
		send_item(OP_STATUS, 16'($urandom), 8'($urandom), 16'($urandom));
	endtask

	task automatic advance_item(logic [15:0] cyc);
		send_item(OP_ADVANCE, 16'($urandom), 8'($urandom), cyc);
	endtask

	// Hold the sender until every predicted result has come back.
	task automatic pause_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic write_scale(logic [SCALE_W-1:0] v);
		pause_until_drained();
		repeat (4) @(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// Enable both channels and give each a fresh control, period and length.
	task automatic setup_channels();
		bus_wr(ENABLE_ADDR, {6'($urandom), 2'b11});
		bus_wr(ADDR_CTRL1, 8'($urandom));
		bus_wr(ADDR_PLO1, 8'($urandom));
		bus_wr(ADDR_PHI1, 8'($urandom));
		bus_wr(ADDR_CTRL2, 8'($urandom));
		bus_wr(ADDR_PLO2, 8'($urandom));
		bus_wr(ADDR_PHI2, 8'($urandom));
		useful_items += 7;
	endtask

	task automatic random_item();
		int k;
		bit ignored;
		logic [7:0] d;
		logic [15:0] cyc;
		k = $urandom_range(0, 99);
		ignored = 1'b0;
		d = 8'($urandom);
		if (k < 40) begin
			sample_item();
		end else if (k < 48) begin
			status_item();
		end else if (k < 58) begin
			case ($urandom_range(0, 9))
				0: cyc = 16'($urandom);
				1, 2: cyc = 16'($urandom_range(3000, 16000));
				default: cyc = 16'($urandom_range(0, 3000));
			endcase
			advance_item(cyc);
		end else if (k < 70) begin
			bus_wr($urandom_range(0, 1) ? ADDR_CTRL2 : ADDR_CTRL1, d);
		end else if (k < 78) begin
			bus_wr($urandom_range(0, 1) ? ADDR_PLO2 : ADDR_PLO1, d);
		end else if (k < 86) begin
			// Clear the high period bits now and then so periods below 8 occur.
			if ($urandom_range(0, 3) == 0)
				d[2:0] = 3'd0;
			bus_wr($urandom_range(0, 1) ? ADDR_PHI2 : ADDR_PHI1, d);
		end else if (k < 92) begin
			if ($urandom_range(0, 9) < 7)
				d[1:0] = 2'b11;
			bus_wr(ENABLE_ADDR, d);
		end else if (k < 96) begin
			ignored = 1'b1;
			case ($urandom_range(0, 2))
				0: bus_wr(ADDR_SWEEP1, d);
				1: bus_wr(ADDR_SWEEP2, d);
				default: bus_wr(ADDR_FRAME, d);
			endcase
		end else begin
			ignored = 1'b1;
			bus_wr(16'($urandom), d);
		end
		if (!ignored)
			useful_items++;
	endtask

	initial begin
		logic [SCALE_W-1:0] phase_scale [NUM_PHASES];
		int p;
		sb = new();
		idle_on = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_WRITE;
		bus_address = '0;
		write_data = '0;
		cycle_count = '0;
		cfg_write_en = 1'b0;
		cfg_write_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset scale.
		status_item();
		sample_item();
		bus_wr(ADDR_PHI1, 8'hF8);      // length loads while disabled
		bus_wr(ENABLE_ADDR, 8'h03);
		status_item();
		bus_wr(ADDR_CTRL1, 8'hFF);     // duty 75%, halted, full volume
		bus_wr(ADDR_PLO1, 8'h07);
		sample_item();                 // period below 8: silent
		bus_wr(ADDR_PLO1, 8'h08);
		sample_item();
		bus_wr(ADDR_CTRL2, 8'h1F);     // duty 12.5%, not halted
		bus_wr(ADDR_PLO2, 8'hFF);
		bus_wr(ADDR_PHI2, 8'h0F);      // period 0x7FF, longest length
		sample_item();
		bus_wr(ADDR_SWEEP1, 8'hFF);
		bus_wr(ADDR_FRAME, 8'hFF);
		bus_wr(16'hFFFF, 8'hAA);
		advance_item(16'hFFFF);        // many ticks in one advance
		advance_item(16'h0000);
		status_item();
		bus_wr(ENABLE_ADDR, 8'h01);    // disabling channel two clears its length
		status_item();
		sample_item();
		bus_wr(ADDR_CTRL1, 8'h9A);
		sample_item();

		phase_scale[0] = {SCALE_W{1'b1}};
		phase_scale[1] = 40'd1;
		phase_scale[2] = {8'($urandom), 32'($urandom)} | 40'd1;
		phase_scale[3] = 40'($urandom_range(1, 32'h0100_0000));
		phase_scale[4] = 40'd10894297763;
		for (p = 0; p < NUM_PHASES; p++) begin
			if (p == NUM_PHASES - 1)
				idle_on = 1'b0;
			write_scale(phase_scale[p]);
			useful_items = 0;
			setup_channels();
			while (useful_items < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 24) == 0)
					setup_channels();
				else if (idle_on && $urandom_range(0, 199) == 0)
					pause_until_drained();
				else
					random_item();
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tpsg_pkg.sv
rtl/tpsg_div.sv
rtl/tpsg_frame.sv
rtl/two_channel_pulse_sound_generator_unit.sv
tb/two_channel_pulse_sound_generator_unit_tb.sv
